### rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared widths, types and helpers for the barycentric weight pipe
// Operand widths of the exact-integer datapath and the per-step state of the
// pipelined restoring divider.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // Coordinate and datapath widths
  localparam int CW  = 32;          // Q16.16 coordinate
  localparam int EW  = CW + 1;      // edge / offset component
  localparam int SW  = 2 * EW;      // one component product
  localparam int VW  = SW + 2;      // sum of three products (n0, n1, m, a0, a1)
  localparam int LW  = 32;          // low slice of a split operand
  localparam int HW  = VW - LW;     // high slice of a split operand
  localparam int NW  = 140;         // det and numerators, exact
  localparam int FRAC = 16;         // Q16.16 fraction bits

  // Divider widths: |num| << 16 fits DN bits, det fits DD bits
  localparam int DN  = 154;
  localparam int DD  = 137;
  localparam int QW  = DN + 1;      // signed quotient
  localparam int FW  = QW + 2;      // 1 - b0 - b1, exact

  localparam logic [FW-1:0] ONE_Q16 = FW'(65536);
  localparam logic [CW-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] SAT_MIN = 32'h8000_0000;

  // State carried by one restoring-division step, both quotients in parallel
  typedef struct packed {
    logic [DD-1:0] d;      // divisor (determinant)
    logic [DD-1:0] rem0;   // partial remainder, lane 0
    logic [DN-1:0] nq0;    // dividend bits still to shift in / quotient bits out
    logic          neg0;   // quotient sign, lane 0
    logic [DD-1:0] rem1;
    logic [DN-1:0] nq1;
    logic          neg1;
    logic          degen;  // determinant was zero
  } div_t;

  // Clamp an exact signed value to 32 bits
  function automatic logic [CW-1:0] sat32(logic signed [FW-1:0] x);
    logic [FW-CW:0] top;
    top = x[FW-1:CW-1];
    if ((&top) || (~|top)) begin
      return x[CW-1:0];
    end else if (x[FW-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

### rtl/bcc_div_step.sv
// ----------------------------------------------------------------------------
// bcc_div_step: one registered restoring-division step, two lanes
// Shifts one dividend bit into each partial remainder, subtracts the divisor
// where it fits and shifts the resulting quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module bcc_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  bcc_pkg::div_t stage_i,
  output logic          valid_o,
  output bcc_pkg::div_t stage_o
);
  import bcc_pkg::*;

  logic [DD:0]   trial0, trial1, diff0, diff1;
  logic          ge0, ge1;
  div_t          stage_d, stage_q;
  logic          valid_q;

  // Trial subtract on both lanes
  always_comb begin
    trial0 = {stage_i.rem0, stage_i.nq0[DN-1]};
    trial1 = {stage_i.rem1, stage_i.nq1[DN-1]};
    diff0  = trial0 - {1'b0, stage_i.d};
    diff1  = trial1 - {1'b0, stage_i.d};
    ge0    = (trial0 >= {1'b0, stage_i.d});
    ge1    = (trial1 >= {1'b0, stage_i.d});

    stage_d      = stage_i;
    stage_d.rem0 = ge0 ? diff0[DD-1:0] : trial0[DD-1:0];
    stage_d.rem1 = ge1 ? diff1[DD-1:0] : trial1[DD-1:0];
    stage_d.nq0  = {stage_i.nq0[DN-2:0], ge0};
    stage_d.nq1  = {stage_i.nq1[DN-2:0], ge1};
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/triangle_barycentric_coords_top.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_coords_top: barycentric weights of a point in a triangle
// Exact-integer Q16.16 datapath followed by a pipelined restoring divider.
// ----------------------------------------------------------------------------
// The block takes one query (point and three corners) per clock while the
// output is not stalled and returns one result per query, in order. Seven
// arithmetic stages form the edges, the squared lengths, the dot products,
// the determinant and both numerators, and the divider setup (wide products
// are split into 32-bit partial products over two stages); then a 154-stage
// divider produces one quotient bit per stage for both weights at once, and
// a final stage applies signs and saturation. Every stage advances together,
// so the sustained rate is one transaction per cycle when the output does
// not stall. A stall on the output freezes the whole pipe, and
// s_axis_tready_o follows it combinationally.
// A zero determinant gives degenerate (tuser) = 1 with all weights zero.
module triangle_barycentric_coords_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata, low to high: point_x, point_y, point_z, vertex0_x, vertex0_y,
  // vertex0_z, vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z
  input  logic [383:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata, low to high: weight_first, weight_second, weight_third
  output logic [95:0]  m_axis_tdata_o,
  // tuser: degenerate
  output logic         m_axis_tuser_o
);
  import bcc_pkg::*;

  logic adv;
  logic [7:1] v_q;

  // Stage 1: edges and offset
  logic signed [EW-1:0] e0_d [3], e1_d [3], dd_d [3];
  logic signed [EW-1:0] e0_q [3], e1_q [3], dd_q [3];
  // Stage 2: component products
  logic signed [SW-1:0] sq0_d [3], sq1_d [3], mm_d [3], pa0_d [3], pa1_d [3];
  logic signed [SW-1:0] sq0_q [3], sq1_q [3], mm_q [3], pa0_q [3], pa1_q [3];
  // Stage 3: dot products
  logic signed [VW-1:0] n0_d, n1_d, m_d, a0_d, a1_d;
  logic signed [VW-1:0] n0_q, n1_q, m_q, a0_q, a1_q;
  // Stage 4: partial products of the six wide products
  logic signed [VW-1:0]       opa [6], opb [6];
  logic signed [2*HW-1:0]     hh_d [6], hh_q [6];
  logic signed [HW+LW:0]      hl_d [6], hl_q [6], lh_d [6], lh_q [6];
  logic [2*LW-1:0]            ll_d [6], ll_q [6];
  // Stage 5: wide products
  logic signed [NW-1:0] prod_d [6], prod_q [6];
  // Stage 6: determinant and numerators
  logic signed [NW-1:0] det_d, num0_d, num1_d, det_q, num0_q, num1_q;
  // Stage 7: divider setup
  logic [NW-1:0] mag0, mag1;
  div_t          ds [DN+1];
  div_t          setup_d, setup_q;
  logic [DN:0]   dv;
  // Output stage
  logic signed [QW-1:0] q0, q1;
  logic signed [FW-1:0] first;
  logic [95:0]          out_data_d, out_data_q;
  logic                 out_user_d, out_user_q, out_valid_q;

  // Whole pipe advances unless a result is waiting and not taken
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Edges e0, e1 and offset d = p - v0
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0_d[k] = EW'($signed(s_axis_tdata_i[CW*(6+k) +: CW]))
              - EW'($signed(s_axis_tdata_i[CW*(3+k) +: CW]));
      e1_d[k] = EW'($signed(s_axis_tdata_i[CW*(9+k) +: CW]))
              - EW'($signed(s_axis_tdata_i[CW*(3+k) +: CW]));
      dd_d[k] = EW'($signed(s_axis_tdata_i[CW*k +: CW]))
              - EW'($signed(s_axis_tdata_i[CW*(3+k) +: CW]));
    end
  end

  // Component products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq0_d[k] = e0_q[k] * e0_q[k];
      sq1_d[k] = e1_q[k] * e1_q[k];
      mm_d[k]  = e0_q[k] * e1_q[k];
      pa0_d[k] = dd_q[k] * e0_q[k];
      pa1_d[k] = dd_q[k] * e1_q[k];
    end
  end

  // Three-term sums
  always_comb begin
    n0_d = VW'(sq0_q[0]) + VW'(sq0_q[1]) + VW'(sq0_q[2]);
    n1_d = VW'(sq1_q[0]) + VW'(sq1_q[1]) + VW'(sq1_q[2]);
    m_d  = VW'(mm_q[0])  + VW'(mm_q[1])  + VW'(mm_q[2]);
    a0_d = VW'(pa0_q[0]) + VW'(pa0_q[1]) + VW'(pa0_q[2]);
    a1_d = VW'(pa1_q[0]) + VW'(pa1_q[1]) + VW'(pa1_q[2]);
  end

  // Split products: n0*n1, m*m, n1*a0, m*a1, n0*a1, m*a0
  always_comb begin
    opa[0] = n0_q; opb[0] = n1_q;
    opa[1] = m_q;  opb[1] = m_q;
    opa[2] = n1_q; opb[2] = a0_q;
    opa[3] = m_q;  opb[3] = a1_q;
    opa[4] = n0_q; opb[4] = a1_q;
    opa[5] = m_q;  opb[5] = a0_q;
    for (int j = 0; j < 6; j++) begin
      hh_d[j] = $signed(opa[j][VW-1:LW]) * $signed(opb[j][VW-1:LW]);
      hl_d[j] = $signed(opa[j][VW-1:LW]) * $signed({1'b0, opb[j][LW-1:0]});
      lh_d[j] = $signed({1'b0, opa[j][LW-1:0]}) * $signed(opb[j][VW-1:LW]);
      ll_d[j] = opa[j][LW-1:0] * opb[j][LW-1:0];
    end
  end

  // Recombine partial products
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      prod_d[j] = (NW'(hh_q[j]) <<< (2 * LW)) + (NW'(hl_q[j]) <<< LW)
                + (NW'(lh_q[j]) <<< LW) + $signed(NW'(ll_q[j]));
    end
  end

  // Gram determinant and numerators
  always_comb begin
    det_d  = prod_q[0] - prod_q[1];
    num0_d = prod_q[2] - prod_q[3];
    num1_d = prod_q[4] - prod_q[5];
  end

  // Divider setup: magnitudes, signs, dividend scaled by 2^16
  always_comb begin
    mag0          = num0_q[NW-1] ? NW'(-num0_q) : NW'(num0_q);
    mag1          = num1_q[NW-1] ? NW'(-num1_q) : NW'(num1_q);
    setup_d.d     = det_q[DD-1:0];
    setup_d.rem0  = '0;
    setup_d.nq0   = {mag0[DN-FRAC-1:0], {FRAC{1'b0}}};
    setup_d.neg0  = num0_q[NW-1];
    setup_d.rem1  = '0;
    setup_d.nq1   = {mag1[DN-FRAC-1:0], {FRAC{1'b0}}};
    setup_d.neg1  = num1_q[NW-1];
    setup_d.degen = (det_q == '0);
  end

  // Front stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[6:1], s_axis_tvalid_i};
    end
  end

  // Front stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e0_q  <= e0_d;   e1_q  <= e1_d;   dd_q  <= dd_d;
      sq0_q <= sq0_d;  sq1_q <= sq1_d;  mm_q  <= mm_d;
      pa0_q <= pa0_d;  pa1_q <= pa1_d;
      n0_q  <= n0_d;   n1_q  <= n1_d;   m_q   <= m_d;
      a0_q  <= a0_d;   a1_q  <= a1_d;
      hh_q  <= hh_d;   hl_q  <= hl_d;   lh_q  <= lh_d;   ll_q <= ll_d;
      prod_q <= prod_d;
      det_q <= det_d;  num0_q <= num0_d; num1_q <= num1_d;
      setup_q <= setup_d;
    end
  end

  // Pipelined divider, one quotient bit per stage
  assign dv[0] = v_q[7];
  assign ds[0] = setup_q;
  for (genvar i = 0; i < DN; i++) begin : g_div
    bcc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv[i]),
      .stage_i (ds[i]),
      .valid_o (dv[i+1]),
      .stage_o (ds[i+1])
    );
  end

  // Signs, first weight and saturation
  always_comb begin
    q0    = ds[DN].neg0 ? -$signed({1'b0, ds[DN].nq0}) : $signed({1'b0, ds[DN].nq0});
    q1    = ds[DN].neg1 ? -$signed({1'b0, ds[DN].nq1}) : $signed({1'b0, ds[DN].nq1});
    first = $signed(ONE_Q16) - FW'(q0) - FW'(q1);
    if (ds[DN].degen) begin
      out_data_d = '0;
    end else begin
      out_data_d = {sat32(FW'(q1)), sat32(FW'(q0)), sat32(first)};
    end
    out_user_d = ds[DN].degen;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv[DN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // A stalled pipe keeps its front valid bits
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("front pipe moved during stall");

  // Gram determinant is never negative
  a_det_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[6] |-> !det_q[NW-1])
    else $error("negative determinant");

  // Degenerate results carry zero weights
  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("degenerate result with nonzero weights");

endmodule

### dv/triangle_barycentric_coords_top_tb.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_coords_top_tb: self-checking bench for the weight pipe
// Drives point/triangle queries (directed corners, then random and
// well-shaped triangles), predicts the weights with exact wide integer
// arithmetic and checks every output transaction in order.
// ----------------------------------------------------------------------------
module triangle_barycentric_coords_top_tb;

  localparam int BIG = 200;   // exact working width
  localparam int PIPE_LAT = 162;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  typedef logic signed [BIG-1:0] big_t;

  typedef struct packed {
    logic        degen;
    logic [31:0] w2;
    logic [31:0] w1;
    logic [31:0] w0;
  } weights_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [383:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [95:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;

  triangle_barycentric_coords_top dut (.*);

  logic [383:0] query_q[$];
  weights_t     weights_q[$];
  int           err_cnt = 0;
  bit           gen_done;
  bit           calm;        // last part of the run: no idling
  int           hold_cycles; // long receiver hold-off
  bit           hold_done;
  bit           in_taken;    // input transaction at the last rising edge
  int           src_gap, sink_gap;
  longint unsigned cycle_cnt;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Exact integer weight computation
  function automatic big_t sx(logic [31:0] v);
    return big_t'(signed'(v));
  endfunction

  function automatic big_t trunc_div(big_t n, big_t d);
    big_t an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q  = an / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic [31:0] clamp32(big_t v);
    if (v > big_t'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (v < -big_t'(64'sh8000_0000)) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic weights_t bary_weights(logic [383:0] q);
    big_t p[3], e0[3], e1[3], dv[3];
    big_t n0, n1, m, det, a0, a1, b0, b1;
    weights_t r;
    for (int k = 0; k < 3; k++) begin
      p[k]  = sx(q[32*k +: 32]);
      e0[k] = sx(q[32*(6+k) +: 32]) - sx(q[32*(3+k) +: 32]);
      e1[k] = sx(q[32*(9+k) +: 32]) - sx(q[32*(3+k) +: 32]);
      dv[k] = p[k] - sx(q[32*(3+k) +: 32]);
    end
    n0 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    n1 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    m  = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    det = n0*n1 - m*m;
    r = '0;
    if (det == 0) begin
      r.degen = 1'b1;
      return r;
    end
    a0 = dv[0]*e0[0] + dv[1]*e0[1] + dv[2]*e0[2];
    a1 = dv[0]*e1[0] + dv[1]*e1[1] + dv[2]*e1[2];
    b0 = trunc_div((n1*a0 - m*a1) * 65536, det);
    b1 = trunc_div((n0*a1 - m*a0) * 65536, det);
    r.w0 = clamp32(big_t'(65536) - b0 - b1);
    r.w1 = clamp32(b0);
    r.w2 = clamp32(b1);
    return r;
  endfunction

  // Packing helpers for stimulus
  function automatic logic [383:0] pack_query(logic [31:0] c[12]);
    logic [383:0] d;
    for (int k = 0; k < 12; k++) d[32*k +: 32] = c[k];
    return d;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [31:0] c[12];
    int mode;
    rst_ni = 1'b0;
    gen_done = 1'b0;
    // directed: extremes and the degenerate cases
    for (int k = 0; k < 12; k++) c[k] = 32'h0;
    query_q.insert(query_q.size(), pack_query(c));    // all corners coincide
    for (int k = 0; k < 12; k++) c[k] = 32'h8000_0000;
    query_q.insert(query_q.size(), pack_query(c));
    for (int k = 0; k < 12; k++) c[k] = 32'h7FFF_FFFF;
    query_q.insert(query_q.size(), pack_query(c));
    for (int k = 0; k < 12; k++) c[k] = 32'hFFFF_FFFF;
    query_q.insert(query_q.size(), pack_query(c));
    // collinear corners
    c = '{32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h2_0000, 32'h2_0000};
    query_q.insert(query_q.size(), pack_query(c));
    // unit right triangle, points at each corner and the centroid
    for (int j = 0; j < 4; j++) begin
      c = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0};
      if (j == 1) c[0] = 32'h1_0000;
      if (j == 2) c[1] = 32'h1_0000;
      if (j == 3) begin c[0] = 32'h5555; c[1] = 32'h5555; end
      query_q.insert(query_q.size(), pack_query(c));
    end
    // huge triangle vs far point: saturation both ways
    c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
          32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0};
    query_q.insert(query_q.size(), pack_query(c));
    c = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
          32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0};
    query_q.insert(query_q.size(), pack_query(c));
    c = '{32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h7FFF_FFFF};
    query_q.insert(query_q.size(), pack_query(c));
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 12; k++) c[k] = rand_coord(3);
      query_q.insert(query_q.size(), pack_query(c));
    end
    // random: mostly well-shaped triangles, some full-range and tiny ones
    for (int i = 0; i < 1700; i++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 1 : (mode < 8) ? 0 : (mode < 9) ? 2 : 3;
      for (int k = 0; k < 12; k++) c[k] = rand_coord(mode);
      if ($urandom_range(0, 19) == 0) begin
        for (int k = 0; k < 3; k++) c[9+k] = c[6+k];  // degenerate
      end
      query_q.insert(query_q.size(), pack_query(c));
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    gen_done = 1'b1;
  end

  // Last part of the run: no idling on either side
  always @(negedge clk_i) begin
    calm <= gen_done && (query_q.size() < 300);
  end

  // Input handshake seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
  end

  // Driver: changes inputs at the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      src_gap         <= 0;
    end else if (!s_axis_tvalid_i || in_taken) begin
      // previous transaction (if any) was taken at the last rising edge
      if (src_gap > 0) begin
        src_gap         <= src_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        src_gap         <= $urandom_range(0, 3);
        s_axis_tvalid_i <= 1'b0;
      end else if (query_q.size() > 0) begin
        s_axis_tdata_i  <= query_q[0];
        weights_q.insert(weights_q.size(), bary_weights(query_q[0]));
        void'(query_q.pop_front());
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with one long hold-off while input keeps coming
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_gap        <= 0;
      hold_cycles     <= 0;
      hold_done       <= 1'b0;
    end else if (!hold_done && query_q.size() < 1400) begin
      hold_done       <= 1'b1;
      hold_cycles     <= 400;
      m_axis_tready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles     <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap        <= sink_gap - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_gap        <= $urandom_range(0, 3);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Monitor: compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    weights_t want;
    weights_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o, m_axis_tdata_o};
      if (weights_q.size() == 0) begin
        $error("unexpected output transaction");
        err_cnt++;
      end else begin
        want = weights_q.pop_front();
        if (got.w0 !== want.w0) begin
          $error("weight_first: exp %h got %h", want.w0, got.w0);
          err_cnt++;
        end
        if (got.w1 !== want.w1) begin
          $error("weight_second: exp %h got %h", want.w1, got.w1);
          err_cnt++;
        end
        if (got.w2 !== want.w2) begin
          $error("weight_third: exp %h got %h", want.w2, got.w2);
          err_cnt++;
        end
        if (got.degen !== want.degen) begin
          $error("degenerate: exp %b got %b", want.degen, got.degen);
          err_cnt++;
        end
      end
    end
  end

  // End of run and timeout
  initial begin
    cycle_cnt = 0;
    while (!(gen_done && query_q.size() == 0 && !s_axis_tvalid_i &&
             weights_q.size() == 0) && cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
    end else begin
      repeat (PIPE_LAT + 20) @(posedge clk_i);
      if (err_cnt == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule
